@@ src/mhpq_pkg.sv @@
`default_nettype none
package mhpq_pkg;

  localparam int unsigned DefDepth    = 64;
  localparam int unsigned DefKeyWidth = 32;
  localparam int unsigned TagWidth    = 16;
  localparam int unsigned CountWidth  = 7;
  localparam int unsigned OutKeyWidth = 32;
  localparam int unsigned InKeyWidth  = 32;

  typedef enum logic [1:0] {
    StOk    = 2'd0,
    StFull  = 2'd1,
    StEmpty = 2'd2
  } status_e;

  typedef enum logic {
    ReqInsert  = 1'b0,
    ReqExtract = 1'b1
  } req_e;

  typedef struct packed {
    logic                  req_type;
    logic [InKeyWidth-1:0] key;
    logic [TagWidth-1:0]   tag;
  } req_t;

  typedef struct packed {
    logic [1:0]             status;
    logic [OutKeyWidth-1:0] out_key;
    logic [TagWidth-1:0]    out_tag;
    logic [CountWidth-1:0]  entry_count;
  } rsp_t;

  typedef enum logic [3:0] {
    FsIdle,
    FsUpRead,
    FsUpCmp,
    FsDnRootRd,
    FsDnLastRd,
    FsDnLeftRd,
    FsDnRightRd,
    FsDnCmp,
    FsDnDone,
    FsRespond
  } fsm_e;

endpackage
`default_nettype wire

@@ src/max_heap_priority_queue_unit.sv @@
// Requests are taken one at a time: the unit stalls its input until the last result
//   has been loaded into the output buffer. The heap memory has a single read port
//   and a single write port.
// Reset: the entry count clears; heap memory contents are not cleared.
`default_nettype none
module max_heap_priority_queue_unit #(
  parameter int unsigned DEPTH     = mhpq_pkg::DefDepth,
  parameter int unsigned KEY_WIDTH = mhpq_pkg::DefKeyWidth
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output      logic          in_stall_o,
  input  wire mhpq_pkg::req_t in_data_i,
  output      logic          out_valid_o,
  input  wire logic          out_stall_i,
  output      mhpq_pkg::rsp_t out_data_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned EW = KEY_WIDTH + mhpq_pkg::TagWidth;

  typedef struct packed {
    logic signed [KEY_WIDTH-1:0]  key;
    logic [mhpq_pkg::TagWidth-1:0] tag;
  } ent_t;

  mhpq_pkg::fsm_e state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [CW-1:0] pos_q, pos_d;     // current slot of the moving entry
  logic [CW-1:0] par_q, par_d;     // parent slot while an inserted entry climbs
  ent_t cur_q, cur_d;              // moving entry
  ent_t lch_q, lch_d;              // left child
  ent_t res_q, res_d;              // extracted root
  logic [1:0] st_q, st_d;
  logic ovld_q, ovld_d;
  mhpq_pkg::rsp_t obuf_q, obuf_d;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  ent_t          wdata, rdata;

  mhpq_ram #(.Width(EW), .Depth(DEPTH)) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  // child indexes carry one extra bit so they never wrap past the count
  logic [CW:0] lidx, ridx, cnt_x;
  assign lidx  = {pos_q, 1'b1};
  assign ridx  = lidx + (CW+1)'(1);
  assign cnt_x = {1'b0, cnt_q};

  logic out_free;
  assign out_free = !ovld_q || !out_stall_i;
  assign in_stall_o = (state_q != mhpq_pkg::FsIdle);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    pos_d   = pos_q;
    par_d   = par_q;
    cur_d   = cur_q;
    lch_d   = lch_q;
    res_d   = res_q;
    st_d    = st_q;
    ovld_d  = ovld_q && out_stall_i;
    obuf_d  = obuf_q;
    we      = 1'b0;
    waddr   = pos_q[AW-1:0];
    wdata   = cur_q;
    raddr   = '0;
    case (state_q)
      mhpq_pkg::FsIdle: begin
        if (in_valid_i) begin
          res_d = '0;
          st_d  = mhpq_pkg::StOk;
          if (in_data_i.req_type == mhpq_pkg::ReqInsert) begin
            if (cnt_q >= CW'(DEPTH)) begin
              st_d    = mhpq_pkg::StFull;
              state_d = mhpq_pkg::FsRespond;
            end else begin
              cur_d.key = KEY_WIDTH'(in_data_i.key);
              cur_d.tag = in_data_i.tag;
              pos_d     = cnt_q;
              cnt_d     = cnt_q + CW'(1);
              state_d   = mhpq_pkg::FsUpRead;
            end
          end else if (cnt_q == '0) begin
            st_d    = mhpq_pkg::StEmpty;
            state_d = mhpq_pkg::FsRespond;
          end else begin
            cnt_d   = cnt_q - CW'(1);
            raddr   = '0;
            state_d = mhpq_pkg::FsDnRootRd;
          end
        end
      end
      mhpq_pkg::FsUpRead: begin
        if (pos_q == '0) begin
          we      = 1'b1;
          state_d = mhpq_pkg::FsRespond;
        end else begin
          par_d   = (pos_q - CW'(1)) >> 1;
          raddr   = AW'((pos_q - CW'(1)) >> 1);
          state_d = mhpq_pkg::FsUpCmp;
        end
      end
      mhpq_pkg::FsUpCmp: begin
        if (cur_q.key > rdata.key) begin
          we      = 1'b1;
          wdata   = rdata;       // parent moves down into our slot
          pos_d   = par_q;
          state_d = mhpq_pkg::FsUpRead;
        end else begin
          we      = 1'b1;
          state_d = mhpq_pkg::FsRespond;
        end
      end
      mhpq_pkg::FsDnRootRd: begin
        // root readout issued in idle arrives here
        res_d   = rdata;
        raddr   = cnt_q[AW-1:0];
        state_d = mhpq_pkg::FsDnLastRd;
      end
      mhpq_pkg::FsDnLastRd: begin
        cur_d   = rdata;
        pos_d   = '0;
        state_d = (cnt_q == '0) ? mhpq_pkg::FsRespond : mhpq_pkg::FsDnLeftRd;
      end
      mhpq_pkg::FsDnLeftRd: begin
        if (lidx >= cnt_x) begin
          we      = 1'b1;
          state_d = mhpq_pkg::FsRespond;
        end else begin
          raddr   = lidx[AW-1:0];
          state_d = mhpq_pkg::FsDnRightRd;
        end
      end
      mhpq_pkg::FsDnRightRd: begin
        lch_d   = rdata;
        raddr   = (ridx < cnt_x) ? ridx[AW-1:0] : lidx[AW-1:0];
        state_d = mhpq_pkg::FsDnCmp;
      end
      mhpq_pkg::FsDnCmp: begin
        // rdata is the right child (or the left again when absent)
        if ((ridx < cnt_x) && (rdata.key > lch_q.key) && (rdata.key > cur_q.key)) begin
          we      = 1'b1;
          wdata   = rdata;
          pos_d   = ridx[CW-1:0];
          state_d = mhpq_pkg::FsDnLeftRd;
        end else if (lch_q.key > cur_q.key) begin
          we      = 1'b1;
          wdata   = lch_q;
          pos_d   = lidx[CW-1:0];
          state_d = mhpq_pkg::FsDnLeftRd;
        end else begin
          we      = 1'b1;
          state_d = mhpq_pkg::FsRespond;
        end
      end
      mhpq_pkg::FsRespond: begin
        if (out_free) begin
          ovld_d             = 1'b1;
          obuf_d.status      = st_q;
          obuf_d.out_key     = mhpq_pkg::OutKeyWidth'($unsigned(res_q.key));
          obuf_d.out_tag     = res_q.tag;
          obuf_d.entry_count = mhpq_pkg::CountWidth'(cnt_q);
          state_d            = mhpq_pkg::FsIdle;
        end
      end
      default: state_d = mhpq_pkg::FsIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mhpq_pkg::FsIdle;
      cnt_q   <= '0;
      ovld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      ovld_q  <= ovld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q  <= pos_d;
    par_q  <= par_d;
    cur_q  <= cur_d;
    lch_q  <= lch_d;
    res_q  <= res_d;
    st_q   <= st_d;
    obuf_q <= obuf_d;
  end

  assign out_valid_o = ovld_q;
  assign out_data_o  = obuf_q;

`ifndef ASSERT_OFF
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(DEPTH)) else $error("count beyond depth");
  a_idle_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mhpq_pkg::FsIdle) |-> !in_stall_o) else $error("idle but stalled");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovld_q && out_stall_i) |=> $stable(obuf_q)) else $error("held result changed");
`endif

endmodule
`default_nettype wire

@@ src/mhpq_ram.sv @@
`default_nettype none
module mhpq_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output      logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire
